>>> hw/rtl/bbrs_pkg.sv
// Package for the Bollinger band reversion signal: sizes, codes, command and status types.
`default_nettype none
package bbrs_pkg;

  localparam int WINDOW_MAX = 64;
  localparam int PRICE_BITS = 24;

  localparam int LEN_BITS  = $clog2(WINDOW_MAX + 1);
  localparam int RING_AW   = $clog2(WINDOW_MAX);
  localparam int SUM_BITS  = PRICE_BITS + LEN_BITS;
  localparam int SQ_BITS   = 2 * PRICE_BITS + LEN_BITS;
  localparam int D_BITS    = SUM_BITS + 1;
  localparam int WIDE_BITS = 2 * SUM_BITS;
  localparam int LIM_BITS  = WIDE_BITS + LEN_BITS;
  localparam int CMP_BITS  = LIM_BITS + 2;

  typedef logic [PRICE_BITS-1:0] price_t;
  typedef logic [LEN_BITS-1:0]   len_t;

  localparam len_t LEN_MIN   = len_t'(2);
  localparam len_t LEN_MAX   = len_t'(WINDOW_MAX);
  localparam len_t LEN_RESET = len_t'(20);

  typedef enum logic [1:0] {
    POS_NEUTRAL = 2'd0,
    POS_ABOVE   = 2'd1,
    POS_BELOW   = 2'd2
  } pos_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SELL = 2'd1,
    ACT_BUY  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_MOMENT,
    ST_SPREAD,
    ST_SCALE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic take;      // input transfer: ring write/read, head and fill update
    logic square;    // squares of new and retired price, N*p
    logic accum;     // running sums update
    logic moment;    // N*Q, S*S, deviation d
    logic spread;    // V = N*Q - S*S, d*d
    logic scale;     // V*N and d*d*(N-1)
    logic load_out;  // tracker update and result register load
  } cmd_t;

  typedef struct packed {
    logic eval;      // window full after this bar, bands are tested
  } status_t;

endpackage
`default_nettype wire

>>> hw/rtl/bbrs_if.sv
// Valid/ready channel interfaces for bar prices in and signals out.
`default_nettype none
interface bbrs_in_if;
  logic             valid;
  logic             ready;
  bbrs_pkg::price_t close_price;

  modport source (output valid, output close_price, input ready);
  modport sink   (input valid, input close_price, output ready);
endinterface

interface bbrs_out_if;
  logic           valid;
  logic           ready;
  bbrs_pkg::act_t action;
  bbrs_pkg::pos_t band_state;
  logic           window_full;

  modport source (output valid, output action, output band_state, output window_full,
                  input ready);
  modport sink   (input valid, input action, input band_state, input window_full,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bbrs_ctrl.sv
// Sequencer for one bar: steps the datapath and owns both handshakes.
`default_nettype none
module bbrs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire bbrs_pkg::status_t status,
  output bbrs_pkg::cmd_t         cmd
);
  import bbrs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SQUARE;
      ST_SQUARE: state_nxt = ST_ACCUM;
      ST_ACCUM:  state_nxt = status.eval ? ST_MOMENT : ST_RESULT;
      ST_MOMENT: state_nxt = ST_SPREAD;
      ST_SPREAD: state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_RESULT;
      ST_RESULT: if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_SQUARE: cmd.square   = 1'b1;
      ST_ACCUM:  cmd.accum    = 1'b1;
      ST_MOMENT: cmd.moment   = 1'b1;
      ST_SPREAD: cmd.spread   = 1'b1;
      ST_SCALE:  cmd.scale    = 1'b1;
      ST_RESULT: cmd.load_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

>>> hw/rtl/bbrs_datapath.sv
// Price ring, running sums, band arithmetic, tracker and result register.
`default_nettype none
module bbrs_datapath (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_write_en,
  input  wire bbrs_pkg::len_t   cfg_write_data,
  input  wire bbrs_pkg::cmd_t   cmd,
  input  wire bbrs_pkg::price_t in_price,
  output bbrs_pkg::status_t     status,
  output bbrs_pkg::act_t        out_action,
  output bbrs_pkg::pos_t        out_band_state,
  output logic                  out_window_full
);
  import bbrs_pkg::*;

  // price ring, one write and one read per bar at the same address
  price_t price_ring [WINDOW_MAX];

  // window state
  len_t                len_r,   len_nxt;
  logic [RING_AW-1:0]  head_r,  head_nxt;
  len_t                fill_r,  fill_nxt;
  logic [SUM_BITS-1:0] sum_r,   sum_nxt;
  logic [SQ_BITS-1:0]  sumsq_r, sumsq_nxt;
  pos_t                pos_r,   pos_nxt;

  // per-bar working registers
  price_t                price_r, old_r;
  logic                  was_full_r, eval_r;
  logic [SQ_BITS-1:0]    sqp_r, sqo_r;
  logic [SUM_BITS-1:0]   np_r;
  logic [WIDE_BITS-1:0]  nq_r, ss_r, v_r, dd_r;
  logic signed [D_BITS-1:0] d_r;
  logic [LIM_BITS-1:0]   lim_r, scl_r;

  act_t act_r;
  pos_t bst_r;
  logic full_r;

  len_t                len_clamp;
  len_t                head_inc;
  len_t                fill_inc;
  len_t                len_m1;
  logic                full_before;
  logic [SUM_BITS-1:0] d_mag;
  logic [CMP_BITS-1:0] lim4, scl_ext;
  logic                d_pos, d_neg, scl_lt, scl_gt;
  logic                in_upper, in_lower;
  act_t                act_dec;
  pos_t                pos_dec;

  assign full_before = (fill_r >= len_r);
  assign head_inc    = len_t'(head_r) + len_t'(1);
  assign fill_inc    = full_before ? fill_r : fill_r + len_t'(1);
  assign len_m1      = len_r - len_t'(1);

  always_comb begin
    priority if (cfg_write_data < LEN_MIN) begin
      len_clamp = LEN_MIN;
    end else if (cfg_write_data > LEN_MAX) begin
      len_clamp = LEN_MAX;
    end else begin
      len_clamp = cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      old_r              <= price_ring[head_r];
      price_ring[head_r] <= in_price;
    end
  end

  // band tests, all in squared form
  assign d_mag   = d_r[D_BITS-1] ? SUM_BITS'(-d_r) : SUM_BITS'(d_r);
  assign lim4    = {lim_r, 2'b00};
  assign scl_ext = CMP_BITS'(scl_r);
  assign d_neg   = d_r[D_BITS-1];
  assign d_pos   = !d_r[D_BITS-1] && (d_r != '0);
  assign scl_lt  = scl_ext < lim4;
  assign scl_gt  = lim4 < scl_ext;
  assign in_upper = d_neg || scl_lt;
  assign in_lower = d_pos || scl_lt;

  always_comb begin
    act_dec = ACT_NONE;
    pos_dec = pos_r;
    if (pos_r == POS_ABOVE && in_upper) begin
      if (d_pos) act_dec = ACT_SELL;
      pos_dec = POS_NEUTRAL;
    end else if (pos_r == POS_BELOW && in_lower) begin
      if (d_neg) act_dec = ACT_BUY;
      pos_dec = POS_NEUTRAL;
    end
    if (pos_dec == POS_NEUTRAL) begin
      if (d_pos && scl_gt) begin
        pos_dec = POS_ABOVE;
      end else if (d_neg && scl_gt) begin
        pos_dec = POS_BELOW;
      end
    end
  end

  always_comb begin
    len_nxt   = len_r;
    head_nxt  = head_r;
    fill_nxt  = fill_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    pos_nxt   = pos_r;
    if (cfg_write_en) begin
      len_nxt   = len_clamp;
      head_nxt  = '0;
      fill_nxt  = '0;
      sum_nxt   = '0;
      sumsq_nxt = '0;
      pos_nxt   = POS_NEUTRAL;
    end else begin
      if (cmd.take) begin
        head_nxt = (head_inc >= len_r) ? '0 : RING_AW'(head_inc);
        fill_nxt = fill_inc;
      end
      if (cmd.accum) begin
        sum_nxt   = sum_r + SUM_BITS'(price_r)
                    - (was_full_r ? SUM_BITS'(old_r) : '0);
        sumsq_nxt = sumsq_r + sqp_r - (was_full_r ? sqo_r : '0);
      end
      if (cmd.load_out && eval_r) begin
        pos_nxt = pos_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_RESET;
      head_r  <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
      pos_r   <= POS_NEUTRAL;
    end else begin
      len_r   <= len_nxt;
      head_r  <= head_nxt;
      fill_r  <= fill_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      price_r    <= in_price;
      was_full_r <= full_before;
      eval_r     <= (fill_inc == len_r);
    end
    if (cmd.square) begin
      sqp_r <= SQ_BITS'(price_r) * SQ_BITS'(price_r);
      sqo_r <= SQ_BITS'(old_r) * SQ_BITS'(old_r);
      np_r  <= SUM_BITS'(price_r) * SUM_BITS'(len_r);
    end
    if (cmd.moment) begin
      nq_r <= WIDE_BITS'(sumsq_r) * WIDE_BITS'(len_r);
      ss_r <= WIDE_BITS'(sum_r) * WIDE_BITS'(sum_r);
      d_r  <= $signed({1'b0, np_r}) - $signed({1'b0, sum_r});
    end
    if (cmd.spread) begin
      v_r  <= nq_r - ss_r;
      dd_r <= WIDE_BITS'(d_mag) * WIDE_BITS'(d_mag);
    end
    if (cmd.scale) begin
      lim_r <= LIM_BITS'(v_r) * LIM_BITS'(len_r);
      scl_r <= LIM_BITS'(dd_r) * LIM_BITS'(len_m1);
    end
    if (cmd.load_out) begin
      act_r  <= eval_r ? act_dec : ACT_NONE;
      bst_r  <= eval_r ? pos_dec : pos_r;
      full_r <= eval_r;
    end
  end

  assign status.eval     = eval_r;
  assign out_action      = act_r;
  assign out_band_state  = bst_r;
  assign out_window_full = full_r;

endmodule
`default_nettype wire

>>> hw/rtl/bollinger_band_reversion_signal.sv
// Top level of the Bollinger band mean-reversion signal block.
//
// One closing price per bar comes in on in_bar; one signal word per bar goes
// out on out_sig. The block keeps the last window_length prices (2..64,
// default 20) in a ring with a running sum S and sum of squares Q. Once the
// window is full it compares d = N*p - S against the bands at mean +/- two
// sample deviations using d*d*(N-1) versus 4*N*(N*Q - S*S), so no square root
// or divider is needed. A tracker (neutral, above, below) reports a sell when
// an excursion above the upper band comes back inside while still over the
// mean, a buy in the mirror case, and then looks for a new excursion in the
// same bar. The sequencer steps each bar through square, accumulate, moment,
// spread, scale and result, skips moment, spread and scale while the window
// is still filling, spreading the multiplies over steps. The result register
// lets the next bar transfer in while the previous result waits; a held
// output only stalls the last step of the following bar. Writing cfg_write_data
// (clamped to 2..64) empties the window and resets the tracker; write it only
// while no bar is in flight.
`default_nettype none
module bollinger_band_reversion_signal (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_write_en,
  input  wire bbrs_pkg::len_t cfg_write_data,
  bbrs_in_if.sink             in_bar,
  bbrs_out_if.source          out_sig
);
  import bbrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: handshakes and step commands
  bbrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bar.valid),
    .in_ready  (in_bar.ready),
    .out_valid (out_sig.valid),
    .out_ready (out_sig.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // ring, sums, band tests, tracker and result payload
  bbrs_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .cmd             (cmd),
    .in_price        (in_bar.close_price),
    .status          (status),
    .out_action      (out_sig.action),
    .out_band_state  (out_sig.band_state),
    .out_window_full (out_sig.window_full)
  );

`ifndef SYNTHESIS
  // a trade always closes the excursion, so the tracker reads neutral
  a_trade_clears_tracker: assert property (@(posedge clk) disable iff (!rst_n)
    out_sig.valid && (out_sig.action != ACT_NONE) |->
      (out_sig.band_state == POS_NEUTRAL) && out_sig.window_full)
    else $error("trade reported with tracker not neutral or window not full");

  // no trade before the window has filled
  a_no_trade_while_filling: assert property (@(posedge clk) disable iff (!rst_n)
    out_sig.valid && !out_sig.window_full |-> out_sig.action == ACT_NONE)
    else $error("trade reported while window filling");

  // one bar at a time: input closes right after a transfer
  a_one_bar_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_bar.valid && in_bar.ready |=> !in_bar.ready)
    else $error("second bar taken while one is in flight");
`endif

endmodule
`default_nettype wire
